[src/mmul_pkg.sv]
`default_nettype none

package mmul_pkg;

    // Fixed field widths of the streams
    localparam int MODE_W = 2;
    localparam int IDX_W  = 4;
    localparam int VAL_W  = 32;

    // Defaults for the top-level parameters
    localparam int DIM_DEFAULT       = 4;
    localparam int FRAC_BITS_DEFAULT = 16;

    // Operation codes carried in the mode field
    localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [IDX_W-1:0]        elem_index;
        logic signed [VAL_W-1:0] elem_value;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]        out_index;
        logic signed [VAL_W-1:0] out_value;
        logic                    out_last;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic wr_a;      // store input element into first matrix
        logic wr_b;      // store input element into second matrix
        logic issue;     // read one operand pair, feed the MAC pipe
        logic first;     // this pair opens a new dot product
        logic last;      // this pair closes the dot product
        logic load_out;  // move the finished sum into the output register
        logic out_last;  // element being loaded is the final one
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic acc_ready; // a complete dot product sits in the accumulator
        logic out_full;  // output register holds an untaken transaction
    } t_status;

endpackage

`default_nettype wire

[src/mmul_stream_if.sv]
`default_nettype none

interface mmul_in_if;
    logic               valid;
    logic               ready;
    mmul_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mmul_out_if;
    logic                valid;
    logic                ready;
    mmul_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[src/mmul_ram.sv]
`default_nettype none

module mmul_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[src/mmul_ctrl.sv]
`default_nettype none

module mmul_ctrl #(
    parameter int DIM = mmul_pkg::DIM_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic [mmul_pkg::MODE_W-1:0]   i_mode,
    output logic                               o_in_ready,
    input  wire mmul_pkg::t_status             i_status,
    output mmul_pkg::t_cmd                     o_cmd,
    output logic [$clog2(DIM*DIM)-1:0]         o_a_addr,
    output logic [$clog2(DIM*DIM)-1:0]         o_b_addr,
    output logic [$clog2(DIM*DIM)-1:0]         o_out_elem
);

    localparam int AW = $clog2(DIM*DIM);
    localparam int CW = $clog2(DIM);
    localparam logic [CW-1:0] CNT_MAX = CW'(DIM - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_i, n_i;   // row of the product element
    logic [CW-1:0] r_j, n_j;   // column of the product element
    logic [CW-1:0] r_k, n_k;   // position along the dot product
    logic          accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // first[i][k] at i + k*DIM, second[k][j] at k + j*DIM
    assign o_a_addr   = AW'(r_i + r_k * DIM);
    assign o_b_addr   = AW'(r_k + r_j * DIM);
    assign o_out_elem = AW'(r_i + r_j * DIM);

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        o_cmd   = '0;
        o_cmd.out_last = (r_i == CNT_MAX) && (r_j == CNT_MAX);

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    priority if (i_mode == mmul_pkg::MODE_LOAD_A) begin
                        o_cmd.wr_a = 1'b1;
                    end else if (i_mode == mmul_pkg::MODE_LOAD_B) begin
                        o_cmd.wr_b = 1'b1;
                    end else if (i_mode == mmul_pkg::MODE_COMPUTE) begin
                        n_i     = '0;
                        n_j     = '0;
                        n_k     = '0;
                        n_state = ST_ISSUE;
                    end else begin
                        // unused mode: transaction dropped
                    end
                end
            end
            ST_ISSUE: begin
                o_cmd.issue = 1'b1;
                o_cmd.first = (r_k == '0);
                o_cmd.last  = (r_k == CNT_MAX);
                if (r_k == CNT_MAX) begin
                    n_k     = '0;
                    n_state = ST_WAIT;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_WAIT: begin
                if (i_status.acc_ready && !i_status.out_full) begin
                    o_cmd.load_out = 1'b1;
                    if (r_i == CNT_MAX) begin
                        n_i = '0;
                        if (r_j == CNT_MAX) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_j     = r_j + 1'b1;
                            n_state = ST_ISSUE;
                        end
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = ST_ISSUE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

`ifndef SYNTH
    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (i_status.acc_ready && !i_status.out_full))
        else $error("result loaded without finished sum or free output");

    a_no_issue_over_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue |-> !i_status.acc_ready)
        else $error("new dot product started over an untaken sum");

    a_last_goes_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.issue && o_cmd.last) |=> (r_state == ST_WAIT))
        else $error("controller left issue phase incorrectly");
`endif

endmodule

`default_nettype wire

[src/mmul_datapath.sv]
`default_nettype none

module mmul_datapath #(
    parameter int DIM       = mmul_pkg::DIM_DEFAULT,
    parameter int FRAC_BITS = mmul_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire mmul_pkg::t_in_item            i_item,
    input  wire mmul_pkg::t_cmd                i_cmd,
    input  wire logic [$clog2(DIM*DIM)-1:0]    i_a_addr,
    input  wire logic [$clog2(DIM*DIM)-1:0]    i_b_addr,
    input  wire logic [$clog2(DIM*DIM)-1:0]    i_out_elem,
    output mmul_pkg::t_status                  o_status,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output mmul_pkg::t_out_item                o_out_item
);

    localparam int ELEMS = DIM * DIM;
    localparam int AW    = $clog2(ELEMS);
    localparam int VW    = mmul_pkg::VAL_W;
    localparam int PW    = 2 * VW;
    localparam int ACC_W = PW + $clog2(DIM);

    logic              in_range;
    logic [AW-1:0]     wr_addr;
    logic              we_a, we_b;
    logic [VW-1:0]     rdata_a, rdata_b;
    logic [ELEMS-1:0]  r_valid_a, r_valid_b;

    // stage 1: operands out of the stores
    logic              r_s1_vld, r_s1_first, r_s1_last;
    logic              r_va, r_vb;
    logic signed [VW-1:0] op_a, op_b;

    // stage 2: product
    logic              r_s2_vld, r_s2_first, r_s2_last;
    logic signed [PW-1:0] r_prod;

    // stage 3: accumulator
    logic signed [ACC_W-1:0] r_acc, acc_sum, shifted;
    logic              r_acc_ready;
    logic              sat_hi, sat_lo;
    logic signed [VW-1:0] sat_value;

    logic              r_out_valid;
    mmul_pkg::t_out_item r_out;

    assign in_range = (32'(i_item.elem_index) < ELEMS);
    assign wr_addr  = AW'(i_item.elem_index);
    assign we_a     = i_cmd.wr_a && in_range;
    assign we_b     = i_cmd.wr_b && in_range;

    mmul_ram #(.WIDTH(VW), .DEPTH(ELEMS)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (wr_addr),
        .i_wdata (i_item.elem_value),
        .i_raddr (i_a_addr),
        .o_rdata (rdata_a)
    );

    mmul_ram #(.WIDTH(VW), .DEPTH(ELEMS)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (wr_addr),
        .i_wdata (i_item.elem_value),
        .i_raddr (i_b_addr),
        .o_rdata (rdata_b)
    );

    // per-entry written flags; unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= '0;
            r_valid_b <= '0;
        end else begin
            if (we_a) r_valid_a[wr_addr] <= 1'b1;
            if (we_b) r_valid_b[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.issue;
            r_s2_vld <= r_s1_vld;
        end
        r_s1_first <= i_cmd.first;
        r_s1_last  <= i_cmd.last;
        r_va       <= r_valid_a[i_a_addr];
        r_vb       <= r_valid_b[i_b_addr];
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_prod     <= op_a * op_b;
    end

    assign op_a = r_va ? $signed(rdata_a) : '0;
    assign op_b = r_vb ? $signed(rdata_b) : '0;

    assign acc_sum = r_s2_first ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (r_s2_vld) begin
            r_acc <= acc_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_ready <= 1'b0;
        end else if (r_s2_vld && r_s2_last) begin
            r_acc_ready <= 1'b1;
        end else if (i_cmd.load_out) begin
            r_acc_ready <= 1'b0;
        end
    end

    // floor shift, then clamp to the 32-bit range
    assign shifted = r_acc >>> FRAC_BITS;
    assign sat_hi  = !shifted[ACC_W-1] && (|shifted[ACC_W-2:VW-1]);
    assign sat_lo  = shifted[ACC_W-1] && !(&shifted[ACC_W-2:VW-1]);

    always_comb begin
        priority if (sat_hi) begin
            sat_value = {1'b0, {(VW-1){1'b1}}};
        end else if (sat_lo) begin
            sat_value = {1'b1, {(VW-1){1'b0}}};
        end else begin
            sat_value = shifted[VW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_out.out_index <= mmul_pkg::IDX_W'(i_out_elem);
            r_out.out_value <= sat_value;
            r_out.out_last  <= i_cmd.out_last;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_item         = r_out;
    assign o_status.acc_ready = r_acc_ready;
    assign o_status.out_full  = r_out_valid;

`ifndef SYNTH
    a_ready_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_acc_ready) |-> $past(r_s2_vld && r_s2_last))
        else $error("sum flagged ready without closing product");

    a_no_load_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !r_out_valid)
        else $error("output register overwritten");
`endif

endmodule

`default_nettype wire

[src/matrix_multiply_4x4_unit.sv]
`default_nettype none

// DIM x DIM signed fixed-point matrix multiplier (4x4, Q16.16 by default).
// Elements are column-major: index i + DIM*j is row i, column j. An input
// transaction with mode 0 or 1 writes one element of the first or second
// matrix (index out of range is dropped); mode 2 computes the product and
// emits DIM*DIM output transactions in ascending index order, out_last set
// on the final one; mode 3 is accepted and ignored. Both matrices read as
// zero after reset until written. Each element is the full-precision sum of
// DIM products, shifted right arithmetically by FRAC_BITS (floor) and
// saturated to 32 bits. One shared 32x32 multiplier does one
// multiply-accumulate per cycle while a dot product is being issued; after
// each element the controller waits until its sum has passed the RAM read,
// product and accumulate stages and the output register is free, then loads
// the output register. New input is accepted only while no compute is
// running; the last result may still sit in the output register.

module matrix_multiply_4x4_unit #(
    parameter int DIM       = mmul_pkg::DIM_DEFAULT,
    parameter int FRAC_BITS = mmul_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mmul_in_if.sink     i_in,
    mmul_out_if.source  o_out
);

    localparam int AW = $clog2(DIM*DIM);

    mmul_pkg::t_cmd      cmd;
    mmul_pkg::t_status   status;
    mmul_pkg::t_out_item out_item;
    logic [AW-1:0]       a_addr, b_addr, out_elem;
    logic                in_ready, out_valid;

    // sequencer: walks row, column and dot-product position
    mmul_ctrl #(.DIM(DIM)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_mode     (i_in.payload.mode),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_a_addr   (a_addr),
        .o_b_addr   (b_addr),
        .o_out_elem (out_elem)
    );

    // element stores, MAC pipe, saturation and output register
    mmul_datapath #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in.payload),
        .i_cmd       (cmd),
        .i_a_addr    (a_addr),
        .i_b_addr    (b_addr),
        .i_out_elem  (out_elem),
        .o_status    (status),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_out_item  (out_item)
    );

    assign i_in.ready    = in_ready;
    assign o_out.valid   = out_valid;
    assign o_out.payload = out_item;

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int MODE_W = mmul_pkg::MODE_W;
    localparam int IDX_W  = mmul_pkg::IDX_W;
    localparam int VAL_W  = mmul_pkg::VAL_W;

    localparam logic [MODE_W-1:0] MODE_LOAD_A  = mmul_pkg::MODE_LOAD_A;
    localparam logic [MODE_W-1:0] MODE_LOAD_B  = mmul_pkg::MODE_LOAD_B;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = mmul_pkg::MODE_COMPUTE;

    typedef mmul_pkg::t_in_item  t_in_item;
    typedef mmul_pkg::t_out_item t_out_item;

    localparam int DIM       = mmul_pkg::DIM_DEFAULT;
    localparam int FRAC_BITS = mmul_pkg::FRAC_BITS_DEFAULT;
    localparam int ELEMS     = DIM * DIM;

    // Mode 3 has no meaning in the block; it must be swallowed silently
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // Q16.16 corner values
    localparam logic [VAL_W-1:0] Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] Q_MIN     = 32'h8000_0000;
    localparam logic [VAL_W-1:0] Q_ONE     = 32'h0001_0000;
    localparam logic [VAL_W-1:0] Q_LSB     = 32'h0000_0001;
    localparam logic [VAL_W-1:0] Q_NEG_LSB = 32'hFFFF_FFFF;

    localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

    localparam int RAND_ITEMS   = 340;
    localparam int DRAIN_CYCLES = 200;
    // Worst case: every transaction a compute with 16 long sink stalls, times a margin
    localparam int CYCLE_LIMIT  = 1_000_000;

    // Directed row: the input transaction plus, for compute rows whose answer is
    // obvious, the product at index 0 and the value of the other 15 elements
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  idx;
        logic [VAL_W-1:0]  val;
        logic              typed;
        logic [VAL_W-1:0]  exp0;
        logic [VAL_W-1:0]  exp_rest;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [0:25] = '{
        '{MODE_COMPUTE, 4'd0,  32'd0,         1'b1, 32'd0,     32'd0}, // after reset
        '{MODE_LOAD_A,  4'd0,  Q_MAX,         1'b0, 32'd0,     32'd0},
        '{MODE_LOAD_B,  4'd0,  Q_MAX,         1'b0, 32'd0,     32'd0},
        '{MODE_COMPUTE, 4'd0,  32'd0,         1'b1, Q_MAX,     32'd0}, // max*max
        '{MODE_LOAD_B,  4'd0,  Q_MIN,         1'b0, 32'd0,     32'd0},
        '{MODE_COMPUTE, 4'd0,  32'd0,         1'b1, Q_MIN,     32'd0}, // max*min
        '{MODE_LOAD_A,  4'd0,  Q_MIN,         1'b0, 32'd0,     32'd0},
        '{MODE_COMPUTE, 4'd0,  32'd0,         1'b1, Q_MAX,     32'd0}, // min*min
        '{MODE_LOAD_A,  4'd0,  Q_ONE,         1'b0, 32'd0,     32'd0},
        '{MODE_COMPUTE, 4'd0,  32'd0,         1'b1, Q_MIN,     32'd0}, // exact min
        '{MODE_LOAD_A,  4'd0,  Q_LSB,         1'b0, 32'd0,     32'd0},
        '{MODE_LOAD_B,  4'd0,  Q_NEG_LSB,     1'b0, 32'd0,     32'd0},
        '{MODE_UNUSED,  4'd0,  32'h0000_0005, 1'b0, 32'd0,     32'd0}, // ignored
        '{MODE_COMPUTE, 4'd0,  32'd0,         1'b1, Q_NEG_LSB, 32'd0}, // floor of -2^-32
        '{MODE_LOAD_A,  4'd4,  Q_MIN,         1'b0, 32'd0,     32'd0},
        '{MODE_LOAD_A,  4'd8,  Q_MIN,         1'b0, 32'd0,     32'd0},
        '{MODE_LOAD_A,  4'd12, Q_MIN,         1'b0, 32'd0,     32'd0},
        '{MODE_LOAD_A,  4'd0,  Q_MIN,         1'b0, 32'd0,     32'd0},
        '{MODE_LOAD_B,  4'd1,  Q_MIN,         1'b0, 32'd0,     32'd0},
        '{MODE_LOAD_B,  4'd2,  Q_MIN,         1'b0, 32'd0,     32'd0},
        '{MODE_LOAD_B,  4'd3,  Q_MIN,         1'b0, 32'd0,     32'd0},
        '{MODE_LOAD_B,  4'd0,  Q_MIN,         1'b0, 32'd0,     32'd0},
        '{MODE_COMPUTE, 4'd0,  32'd0,         1'b1, Q_MAX,     32'd0}, // sum past 64 bits
        '{MODE_LOAD_A,  4'd15, 32'hAAAA_5555, 1'b0, 32'd0,     32'd0},
        '{MODE_LOAD_B,  4'd15, 32'h5555_AAAA, 1'b0, 32'd0,     32'd0},
        '{MODE_COMPUTE, 4'd15, 32'hFFFF_FFFF, 1'b0, 32'd0,     32'd0}
    };

    typedef enum {PROF_SMALL, PROF_MID, PROF_FULL, PROF_EDGE} t_val_prof;

    logic i_clk;
    logic i_rst_n;

    mmul_in_if  in_if ();
    mmul_out_if out_if ();

    matrix_multiply_4x4_unit #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Shadow copies of both operand stores, zero after reset like the block
    logic signed [VAL_W-1:0] mat_a [ELEMS];
    logic signed [VAL_W-1:0] mat_b [ELEMS];

    // Product transactions still owed by the block, oldest first
    t_out_item pending_products [$];

    int  mismatches;
    int  cycle_cnt;
    bit  idle_en;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Random gap length: mostly none or short, now and then a long one.
    // With idle_en low both sides run flat out.
    function automatic int gap_len();
        int r;
        if (!idle_en)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // One product element: full-precision dot product of row i of A and
    // column j of B, floor shift by FRAC_BITS, saturate to 32 bits.
    // 66 bits hold four 64-bit products without wrap (four min*min = 2^64).
    function automatic logic [VAL_W-1:0] fx_dot(int i, int j);
        logic signed [65:0] acc;
        logic signed [63:0] prod;
        logic signed [65:0] shifted;
        acc = '0;
        for (int k = 0; k < DIM; k++) begin
            prod = mat_a[i + k*DIM] * mat_b[k + j*DIM];
            acc  = acc + prod;
        end
        shifted = acc >>> FRAC_BITS;
        if (shifted > SAT_HI)
            return Q_MAX;
        if (shifted < SAT_LO)
            return Q_MIN;
        return shifted[VAL_W-1:0];
    endfunction

    // Update the shadow state for an accepted input transaction and queue
    // whatever products it owes. Typed rows replace the computed values.
    task automatic apply_item(input t_in_item it, input bit typed,
                              input logic [VAL_W-1:0] e0, input logic [VAL_W-1:0] er);
        t_out_item r;
        int        e;
        case (it.mode)
            MODE_LOAD_A: begin
                if (it.elem_index < ELEMS)
                    mat_a[it.elem_index] = it.elem_value;
            end
            MODE_LOAD_B: begin
                if (it.elem_index < ELEMS)
                    mat_b[it.elem_index] = it.elem_value;
            end
            MODE_COMPUTE: begin
                // column-major emit order: index i + DIM*j ascending
                for (int j = 0; j < DIM; j++) begin
                    for (int i = 0; i < DIM; i++) begin
                        e           = i + j*DIM;
                        r.out_index = IDX_W'(e);
                        if (typed)
                            r.out_value = (e == 0) ? e0 : er;
                        else
                            r.out_value = fx_dot(i, j);
                        r.out_last  = (e == ELEMS - 1);
                        pending_products.push_back(r);
                    end
                end
            end
            default: begin
                // unused mode: no state change, nothing owed
            end
        endcase
    endtask

    // Drive one input transaction, hold it until accepted, then maybe idle.
    // valid is only lowered when a gap follows, so it never toggles within a step.
    task automatic send_item(input t_in_item it, input bit typed,
                             input logic [VAL_W-1:0] e0, input logic [VAL_W-1:0] er);
        int          g;
        logic [63:0] junk;
        in_if.valid   <= 1'b1;
        in_if.payload <= it;
        do
            @(posedge i_clk);
        while (in_if.ready !== 1'b1);
        apply_item(it, typed, e0, er);
        g = gap_len();
        if (g != 0) begin
            junk          = {$urandom, $urandom};
            in_if.valid   <= 1'b0;
            in_if.payload <= junk[$bits(t_in_item)-1:0];
            repeat (g) @(posedge i_clk);
        end
    endtask

    function automatic logic [VAL_W-1:0] rand_elem(t_val_prof prof);
        logic [VAL_W-1:0] v;
        case (prof)
            // +/-4.0: sums never saturate
            PROF_SMALL: v = 32'($urandom_range(0, 32'h0007_FFFF)) - 32'h0004_0000;
            // +/-256.0: sums land on both sides of the saturation limit
            PROF_MID:   v = 32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
            PROF_FULL:  v = $urandom;
            default: begin
                case ($urandom_range(0, 6))
                    0:       v = Q_MAX;
                    1:       v = Q_MIN;
                    2:       v = 32'd0;
                    3:       v = Q_LSB;
                    4:       v = Q_NEG_LSB;
                    5:       v = Q_ONE;
                    default: v = -Q_ONE;
                endcase
            end
        endcase
        return v;
    endfunction

    // Output side: ready drops for a random stretch, usually right after a
    // transaction, sometimes while the block is still busy.
    initial begin
        int hold;
        int g;
        out_if.ready = 1'b0;
        hold         = 0;
        forever begin
            @(posedge i_clk);
            if (hold != 0) begin
                hold = hold - 1;
                if (hold == 0)
                    out_if.ready <= 1'b1;
            end else begin
                g = i_rst_n ? gap_len() : 0;
                if (g != 0 && ((out_if.valid === 1'b1 && out_if.ready === 1'b1) ||
                               $urandom_range(0, 7) == 0)) begin
                    out_if.ready <= 1'b0;
                    hold = g;
                end else begin
                    out_if.ready <= 1'b1;
                end
            end
        end
    end

    // Scoreboard: every product transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (pending_products.size() == 0) begin
                $display("%0t: unexpected product transaction index %0d value %h last %b",
                         $time, out_if.payload.out_index, out_if.payload.out_value,
                         out_if.payload.out_last);
                mismatches++;
            end else begin
                want = pending_products.pop_front();
                if (out_if.payload.out_index !== want.out_index) begin
                    $display("%0t: out_index expected %0d actual %0d",
                             $time, want.out_index, out_if.payload.out_index);
                    mismatches++;
                end
                if (out_if.payload.out_value !== want.out_value) begin
                    $display("%0t: out_value at index %0d expected %h actual %h",
                             $time, want.out_index, want.out_value,
                             out_if.payload.out_value);
                    mismatches++;
                end
                if (out_if.payload.out_last !== want.out_last) begin
                    $display("%0t: out_last at index %0d expected %b actual %b",
                             $time, want.out_index, want.out_last,
                             out_if.payload.out_last);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        t_in_item  it;
        t_dir_row  row;
        t_val_prof prof;
        int        sent;
        int        nloads;

        mismatches    = 0;
        idle_en       = 1'b1;
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        for (int n = 0; n < ELEMS; n++) begin
            mat_a[n] = '0;
            mat_b[n] = '0;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: corners of the arithmetic, mode 3, last index
        for (int n = 0; n < $size(DIR_ROWS); n++) begin
            row           = DIR_ROWS[n];
            it.mode       = row.mode;
            it.elem_index = row.idx;
            it.elem_value = row.val;
            send_item(it, row.typed, row.exp0, row.exp_rest);
        end

        // Random: bursts of loads with random content, then a compute.
        // Some bursts end without a compute or with two, some carry mode 3 noise.
        sent = 0;
        while (sent < RAND_ITEMS) begin
            prof    = t_val_prof'($urandom_range(0, 3));
            idle_en = ($urandom_range(0, 3) != 0);
            nloads  = $urandom_range(1, 20);
            for (int n = 0; n < nloads; n++) begin
                it.elem_index = IDX_W'($urandom);
                if ($urandom_range(0, 19) == 0) begin
                    it.mode       = MODE_UNUSED;
                    it.elem_value = $urandom;
                    send_item(it, 1'b0, '0, '0);
                end else begin
                    it.mode       = $urandom_range(0, 1) ? MODE_LOAD_B : MODE_LOAD_A;
                    it.elem_value = rand_elem(prof);
                    send_item(it, 1'b0, '0, '0);
                    sent++;
                end
            end
            if ($urandom_range(0, 9) != 0) begin
                it.mode       = MODE_COMPUTE;
                it.elem_index = IDX_W'($urandom);
                it.elem_value = $urandom;
                send_item(it, 1'b0, '0, '0);
                sent++;
                if ($urandom_range(0, 9) == 0) begin
                    send_item(it, 1'b0, '0, '0);
                    sent++;
                end
            end
        end
        in_if.valid <= 1'b0;

        // Drain, then give the block time to show any stray transaction
        while (pending_products.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

[files.f]
src/mmul_pkg.sv
src/mmul_stream_if.sv
src/mmul_ram.sv
src/mmul_ctrl.sv
src/mmul_datapath.sv
src/matrix_multiply_4x4_unit.sv
tb/tb_top.sv
